// ===== hw/rtl/lrupr_pkg.sv =====
package lrupr_pkg;

  localparam int unsigned PageW        = 16;
  localparam int unsigned StampW       = 32;
  localparam int unsigned FaultW       = 16;
  localparam int unsigned CfgW         = 4;
  localparam int unsigned FrameOutW    = 3;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned NumFramesDef = 8;

  localparam logic [CfgW-1:0]   CfgReset   = CfgW'(8);
  localparam logic [StampW-1:0] StampMax   = {StampW{1'b1}};
  localparam logic [StampW-1:0] StampReset = StampW'(1);
  localparam logic [FaultW-1:0] FaultMax   = {FaultW{1'b1}};

  // Search token that walks down the row of frame cells.
  typedef struct packed {
    logic              vld;
    logic [PageW-1:0]  page;
    logic              hit;
    logic [IdxW-1:0]   hit_idx;
    logic              empty;
    logic [IdxW-1:0]   empty_idx;
    logic              min_set;
    logic [StampW-1:0] min_stamp;
    logic [IdxW-1:0]   min_idx;
    logic [PageW-1:0]  min_tag;
  } probe_t;

  // Write-back broadcast to all cells at the end of a transaction.
  typedef struct packed {
    logic              we;
    logic              miss;
    logic [IdxW-1:0]   idx;
    logic [PageW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } upd_t;

endpackage

// ===== hw/rtl/lru_page_replacement_unit.sv =====
// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    page_i
// output    out_valid_o / out_stall_i  hit_o, frame_index_o, evicted_valid_o,
//                                      evicted_page_o, fault_count_o
// config    cfg_we_i                   cfg_wdata_i
//
// In a transaction the search token passes one frame cell per cycle; its result is
// then captured into a register and written back to the frame cells.
// Reset empties all frames, sets the stamp counter to one and the fault count to zero.
// The input is stalled from acceptance until write-back; write-back waits while a
// previous result is held by a stalled output.
module lru_page_replacement_unit #(
  parameter int unsigned NUM_FRAMES = lrupr_pkg::NumFramesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lrupr_pkg::PageW-1:0]     page_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [lrupr_pkg::FrameOutW-1:0] frame_index_o,
  output logic                            evicted_valid_o,
  output logic [lrupr_pkg::PageW-1:0]     evicted_page_o,
  output logic [lrupr_pkg::FaultW-1:0]    fault_count_o,
  input  logic                            cfg_we_i,
  input  logic [lrupr_pkg::CfgW-1:0]      cfg_wdata_i
);
  import lrupr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CfgW-1:0]      cfg_q;
  logic [StampW-1:0]    stamp_q;
  logic [FaultW-1:0]    faults_q, faults_d;
  probe_t               res_q;
  probe_t               launch;
  probe_t               chain [NUM_FRAMES+1];
  logic [NUM_FRAMES-1:0] active;
  logic [NUM_FRAMES-1:0] probe_vld;
  upd_t                 upd;
  logic                 in_accept;
  logic                 out_free;
  logic                 commit;
  logic [IdxW-1:0]      slot;
  logic                 evict;

  logic                 out_valid_q;
  logic                 hit_q;
  logic [FrameOutW-1:0] frame_q;
  logic                 ev_valid_q;
  logic [PageW-1:0]     ev_page_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_COMMIT) && out_free;

  always_comb begin
    launch      = '0;
    launch.vld  = in_accept;
    launch.page = page_i;
  end

  assign chain[0] = launch;

  for (genvar gi = 0; gi < NUM_FRAMES; gi++) begin : g_cell
    assign active[gi]    = (gi == 0) || (32'(gi) < 32'(cfg_q));
    assign probe_vld[gi] = chain[gi+1].vld;
    lrupr_cell #(
      .INDEX(gi)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .active_i(active[gi]),
      .probe_i (chain[gi]),
      .probe_o (chain[gi+1]),
      .upd_i   (upd)
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (chain[NUM_FRAMES].vld) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    evict = !res_q.hit && !res_q.empty;
    priority if (res_q.hit) begin
      slot = res_q.hit_idx;
    end else if (res_q.empty) begin
      slot = res_q.empty_idx;
    end else begin
      slot = res_q.min_idx;
    end
    faults_d = faults_q;
    if (!res_q.hit && (faults_q != FaultMax)) begin
      faults_d = faults_q + FaultW'(1);
    end
    upd.we    = commit;
    upd.miss  = !res_q.hit;
    upd.idx   = slot;
    upd.tag   = res_q.page;
    upd.stamp = stamp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CfgReset;
      stamp_q     <= StampReset;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (commit) begin
        faults_q <= faults_d;
        if (stamp_q != StampMax) begin
          stamp_q <= stamp_q + StampW'(1);
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_WALK) && chain[NUM_FRAMES].vld) begin
      res_q <= chain[NUM_FRAMES];
    end
    if (commit) begin
      hit_q      <= res_q.hit;
      frame_q    <= slot[FrameOutW-1:0];
      ev_valid_q <= evict;
      ev_page_q  <= evict ? res_q.min_tag : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = faults_q;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(probe_vld))
    else $error("More than one search token in the frame row.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !(out_valid_q && out_stall_i))
    else $error("Write-back overwrote a pending result.");

  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (faults_q >= $past(faults_q)))
    else $error("Fault count decreased.");

  a_stamp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_q != '0)
    else $error("Stamp counter reached zero.");
`endif

endmodule

// ===== hw/rtl/lrupr_cell.sv =====
module lrupr_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              active_i,
  input  lrupr_pkg::probe_t probe_i,
  output lrupr_pkg::probe_t probe_o,
  input  lrupr_pkg::upd_t   upd_i
);
  import lrupr_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

  logic [PageW-1:0]  tag_q;
  logic              valid_q;
  logic [StampW-1:0] stamp_q;
  probe_t            probe_d;
  probe_t            probe_q;

  always_comb begin
    probe_d = probe_i;
    if (active_i) begin
      if (valid_q && (tag_q == probe_i.page) && !probe_i.hit) begin
        probe_d.hit     = 1'b1;
        probe_d.hit_idx = MyIdx;
      end
      if (!valid_q && !probe_i.empty) begin
        probe_d.empty     = 1'b1;
        probe_d.empty_idx = MyIdx;
      end
      if (!probe_i.min_set || (stamp_q < probe_i.min_stamp)) begin
        probe_d.min_set   = 1'b1;
        probe_d.min_stamp = stamp_q;
        probe_d.min_idx   = MyIdx;
        probe_d.min_tag   = tag_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
      stamp_q <= '0;
    end else if (upd_i.we && (upd_i.idx == MyIdx)) begin
      if (upd_i.miss) begin
        tag_q <= upd_i.tag;
      end
      valid_q <= 1'b1;
      stamp_q <= upd_i.stamp;
    end
  end

  assign probe_o = probe_q;

endmodule

// ===== bench/lru_page_replacement_unit_test.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_unit_test;
  import lrupr_pkg::*;

  localparam int NFrames    = NumFramesDef;
  localparam int CycleLimit = 5_000_000;

  typedef struct packed {
    logic                 hit;
    logic [FrameOutW-1:0] frame;
    logic                 ev_valid;
    logic [PageW-1:0]     ev_page;
    logic [FaultW-1:0]    faults;
  } page_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [PageW-1:0]     page_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 hit_o;
  logic [FrameOutW-1:0] frame_index_o;
  logic                 evicted_valid_o;
  logic [PageW-1:0]     evicted_page_o;
  logic [FaultW-1:0]    fault_count_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;

  // Shadow copy of the frame table and the replacement state.
  logic [CfgW-1:0]   frames_cfg = CfgReset;
  logic [PageW-1:0]  tag_mem [NFrames];
  logic              valid_mem [NFrames];
  logic [StampW-1:0] stamp_mem [NFrames];
  logic [StampW-1:0] stamp_next = StampReset;
  logic [FaultW-1:0] fault_total = '0;

  logic [PageW-1:0] pending_pages [$];
  page_result_t     expected_results [$];
  page_result_t     want;
  int               items_queued = 0;
  int               results_seen = 0;
  int               error_count = 0;
  int               cycle_count = 0;
  int               gap_left = 0;
  int               stall_left = 0;
  bit               gaps_on = 1'b1;
  bit               stall_on = 1'b1;

  lru_page_replacement_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_i         (page_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_count_o  (fault_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < NFrames; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      stamp_mem[i] = '0;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Looks up a page, picks the frame to fill on a fault and updates the shadow state.
  function automatic page_result_t predict_access(logic [PageW-1:0] page);
    int           n;
    int           slot;
    bit           found;
    bit           empty;
    page_result_t r;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > NFrames) ? NFrames : int'(frames_cfg));
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && valid_mem[i] && tag_mem[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !valid_mem[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (stamp_mem[i] < stamp_mem[slot]) slot = i;
        end
        r.ev_valid = 1'b1;
        r.ev_page = tag_mem[slot];
      end
      tag_mem[slot] = page;
      valid_mem[slot] = 1'b1;
      if (fault_total != FaultMax) fault_total++;
    end
    stamp_mem[slot] = stamp_next;
    if (stamp_next != StampMax) stamp_next++;
    r.hit = found;
    r.frame = slot[FrameOutW-1:0];
    r.faults = fault_total;
    return r;
  endfunction

  task automatic queue_page(logic [PageW-1:0] page);
    pending_pages.push_back(page);
    items_queued++;
  endtask

  task automatic wait_for_results();
    wait (results_seen == items_queued);
  endtask

  task automatic set_frame_count(logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    frames_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(predict_access(page_i));
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pages.size() != 0) begin
        in_valid_i <= 1'b1;
        page_i <= pending_pages.pop_front();
        gap_left <= gaps_on ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction waiting for it");
      end else begin
        want = expected_results.pop_front();
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit got %0d expected %0d", hit_o, want.hit));
        if (frame_index_o !== want.frame)
          report_mismatch($sformatf("frame_index got %0d expected %0d",
                                    frame_index_o, want.frame));
        if (evicted_valid_o !== want.ev_valid)
          report_mismatch($sformatf("evicted_valid got %0d expected %0d",
                                    evicted_valid_o, want.ev_valid));
        if (evicted_page_o !== want.ev_page)
          report_mismatch($sformatf("evicted_page got %h expected %h",
                                    evicted_page_o, want.ev_page));
        if (fault_count_o !== want.faults)
          report_mismatch($sformatf("fault_count got %h expected %h",
                                    fault_count_o, want.faults));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[lru_page_replacement_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int                n;
    int                ws;
    int                r;
    logic [PageW-1:0]  base;
    logic [PageW-1:0]  last_page;
    logic [CfgW-1:0]   count_value;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill all frames, hit, then evict the least recently used pages.
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h5555);
    queue_page(16'hAAAA);
    queue_page(16'h0000);
    for (int i = 1; i <= 4; i++) queue_page(PageW'(i));
    queue_page(16'hFFFF);
    queue_page(16'h0005);
    queue_page(16'h5555);
    wait_for_results();

    // A count of zero acts as one frame, which can leave a duplicate resident copy.
    set_frame_count(4'd0);
    queue_page(16'h0000);
    queue_page(16'h00FF);
    queue_page(16'hFFFF);
    wait_for_results();
    set_frame_count(4'd2);
    queue_page(16'hFFFF);
    queue_page(16'h0001);
    wait_for_results();

    // Counts above the number of frames act as the full table.
    set_frame_count(4'd15);
    queue_page(16'h0003);
    queue_page(16'h7777);
    wait_for_results();
    set_frame_count(4'd9);
    queue_page(16'h0004);
    queue_page(16'h8000);
    wait_for_results();

    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 0) count_value = 4'd1;
      else if (ph == 1) count_value = 4'd8;
      else if (ph == 2) count_value = 4'd15;
      else count_value = CfgW'($urandom_range(0, 15));
      set_frame_count(count_value);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      n = (count_value == 0) ? 1 : ((count_value > NFrames) ? NFrames : int'(count_value));
      ws = n + $urandom_range(0, 3);
      base = PageW'($urandom_range(0, 65535 - 16));
      last_page = base;
      for (int k = 0; k < 150; k++) begin
        r = $urandom_range(0, 9);
        if (k % 50 == 49) begin
          base = PageW'($urandom_range(0, 65535 - 16));
          ws = $urandom_range(1, n + 3);
        end
        if (r < 7) last_page = base + PageW'($urandom_range(0, ws - 1));
        else if (r == 7) last_page = PageW'($urandom_range(0, 65535));
        queue_page(last_page);
      end
      wait_for_results();
    end

    repeat (NFrames * 4) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("[lru_page_replacement_unit] OK");
    end else begin
      $display("[lru_page_replacement_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== lru_page_replacement_unit.f =====
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_cell.sv
hw/rtl/lru_page_replacement_unit.sv
bench/lru_page_replacement_unit_test.sv
